// File: src/itda_pkg.sv
// Shared constants for the integer to decimal ASCII converter.
package itda_pkg;

	// Width of one BCD digit.
	localparam int DIGIT_W = 4;

	// ASCII codes that the converter emits.
	localparam logic [6:0] CHAR_ZERO  = 7'h30;
	localparam logic [6:0] CHAR_MINUS = 7'h2D;
	localparam logic [6:0] CHAR_LF    = 7'h0A;

	// Pipeline handshake between two stages.
	typedef struct packed {
		logic valid;
		logic neg;
		logic nl;
	} stage_ctl_t;

endpackage

// File: src/itda_dabble_stage.sv
// One registered stage of the shift-and-add-3 binary to BCD converter.
module itda_dabble_stage #(
	parameter int NB    = 32,
	parameter int BW    = 40,
	parameter int STEPS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  itda_pkg::stage_ctl_t   in_ctl,
	input  logic [NB-1:0]          in_bin,
	input  logic [BW-1:0]          in_bcd,
	output logic                   in_ready,
	input  logic                   out_ready,
	output itda_pkg::stage_ctl_t   out_ctl,
	output logic [NB-1:0]          out_bin,
	output logic [BW-1:0]          out_bcd
);

	localparam int ND = BW / itda_pkg::DIGIT_W;

	logic [NB-1:0] bin_t;
	logic [BW-1:0] bcd_t;
	logic          vld_s;
	logic          neg_s;
	logic          nl_s;
	logic [NB-1:0] bin_s;
	logic [BW-1:0] bcd_s;

	// A stage takes new data when it is empty or its content moves on.
	assign in_ready = !vld_s || out_ready;

	// Several shift steps, each preceded by the add-3 correction of every digit.
	always_comb begin
		bin_t = in_bin;
		bcd_t = in_bcd;
		for (int s = 0; s < STEPS; s++) begin
			for (int d = 0; d < ND; d++) begin
				if (bcd_t[d*itda_pkg::DIGIT_W +: itda_pkg::DIGIT_W] >= 4'd5) begin
					bcd_t[d*itda_pkg::DIGIT_W +: itda_pkg::DIGIT_W] =
						bcd_t[d*itda_pkg::DIGIT_W +: itda_pkg::DIGIT_W] + 4'd3;
				end
			end
			{bcd_t, bin_t} = {bcd_t, bin_t} << 1;
		end
	end

	// Valid bit of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= 1'b0;
		end else if (in_ready) begin
			vld_s <= in_ctl.valid;
		end
	end

	// Payload of the stage.
	always_ff @(posedge clk) begin
		if (in_ready && in_ctl.valid) begin
			bin_s <= bin_t;
			bcd_s <= bcd_t;
			neg_s <= in_ctl.neg;
			nl_s  <= in_ctl.nl;
		end
	end

	assign out_ctl.valid = vld_s;
	assign out_ctl.neg   = neg_s;
	assign out_ctl.nl    = nl_s;
	assign out_bin       = bin_s;
	assign out_bcd       = bcd_s;

endmodule

// File: src/int_to_decimal_ascii.sv
// Top level of the signed integer to decimal ASCII converter.
//
// A request is taken at a clock edge where start is high and busy is low. The
// value passes a capture register, a negation stage, four shift-and-add-3
// BCD stages and a leading-digit search stage, seven registers in all, and
// then a character serializer sends its text one character per cycle with
// strobe high: an optional '-', the digits with the most significant first
// (a single '0' for zero), and a line feed when add_newline was set; last
// marks the final character. One request therefore holds the output until its
// last character, and the sustained rate is set by that serializer. The
// pipeline takes a new request every cycle while it has room; busy rises
// only when all stages hold requests waiting for the serializer. Results
// cannot be held off and must be taken in the cycle that strobe is high.
module int_to_decimal_ascii #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] value,
	input  logic        add_newline,
	output logic        strobe,
	output logic [6:0]  character,
	output logic        last
);

	localparam int W     = VALUE_WIDTH;
	localparam int ND    = ((W - 1) * 30103) / 100000 + 1;
	localparam int BW    = ND * itda_pkg::DIGIT_W;
	localparam int NSTG  = 4;
	localparam int STEPS = (W + NSTG - 1) / NSTG;
	localparam int NB    = NSTG * STEPS;
	localparam int IW    = (ND > 1) ? $clog2(ND) : 1;

	// Serializer state codes.
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SIGN  = 2'd1;
	localparam logic [1:0] ST_DIGIT = 2'd2;
	localparam logic [1:0] ST_NL    = 2'd3;

	logic                 vld_s1, rdy_s1, nl_s1;
	logic [W-1:0]         value_s1;
	logic                 vld_s2, rdy_s2, neg_s2, nl_s2;
	logic [W-1:0]         mag_s2;
	logic                 vld_s7, rdy_s7, neg_s7, nl_s7;
	logic [IW-1:0]        msd_s7;
	logic [3:0]           dig_s7 [ND];
	itda_pkg::stage_ctl_t ctl_d  [NSTG+1];
	logic [NB-1:0]        bin_d  [NSTG+1];
	logic [BW-1:0]        bcd_d  [NSTG+1];
	logic                 rdy_d  [NSTG+1];
	logic [IW-1:0]        msd_c;
	logic [W-1:0]         mag_c;

	logic [1:0]           st_q;
	logic [IW-1:0]        pos_q;
	logic                 nl_q;
	logic [3:0]           dig_q [ND];
	logic                 strobe_q, last_q;
	logic [6:0]           char_q;

	logic                 emit;
	logic                 done;
	logic                 ser_ready;
	logic [6:0]           char_c;
	logic                 last_c;
	logic [1:0]           st_n;
	logic [IW-1:0]        pos_n;

	// Capture stage.
	assign rdy_s1 = !vld_s1 || rdy_s2;
	assign busy   = !rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rdy_s1) begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && start) begin
			value_s1 <= value[W-1:0];
			nl_s1    <= add_newline;
		end
	end

	// Magnitude stage: the two's complement negation stays unsigned, so the
	// most negative value keeps its full magnitude.
	assign rdy_s2 = !vld_s2 || rdy_d[0];
	assign mag_c  = value_s1[W-1] ? (~value_s1 + W'(1)) : value_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (rdy_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && vld_s1) begin
			mag_s2 <= mag_c;
			neg_s2 <= value_s1[W-1];
			nl_s2  <= nl_s1;
		end
	end

	// BCD conversion stages; the magnitude sits in the low bits so that the
	// extra leading zero bits shift in first and leave the result unchanged.
	assign ctl_d[0].valid = vld_s2;
	assign ctl_d[0].neg   = neg_s2;
	assign ctl_d[0].nl    = nl_s2;
	assign bin_d[0]       = NB'(mag_s2);
	assign bcd_d[0]       = '0;
	assign rdy_d[NSTG]    = rdy_s7;

	for (genvar g = 0; g < NSTG; g++) begin : g_dabble
		itda_dabble_stage #(
			.NB    (NB),
			.BW    (BW),
			.STEPS (STEPS)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_ctl    (ctl_d[g]),
			.in_bin    (bin_d[g]),
			.in_bcd    (bcd_d[g]),
			.in_ready  (rdy_d[g]),
			.out_ready (rdy_d[g+1]),
			.out_ctl   (ctl_d[g+1]),
			.out_bin   (bin_d[g+1]),
			.out_bcd   (bcd_d[g+1])
		);
	end

	// Leading digit search; an all-zero value starts at the lowest digit.
	always_comb begin
		msd_c = '0;
		for (int d = 0; d < ND; d++) begin
			if (bcd_d[NSTG][d*itda_pkg::DIGIT_W +: itda_pkg::DIGIT_W] != '0) begin
				msd_c = IW'(d);
			end
		end
	end

	assign rdy_s7 = !vld_s7 || ser_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (rdy_s7) begin
			vld_s7 <= ctl_d[NSTG].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s7 && ctl_d[NSTG].valid) begin
			msd_s7 <= msd_c;
			neg_s7 <= ctl_d[NSTG].neg;
			nl_s7  <= ctl_d[NSTG].nl;
			for (int d = 0; d < ND; d++) begin
				dig_s7[d] <= bcd_d[NSTG][d*itda_pkg::DIGIT_W +: itda_pkg::DIGIT_W];
			end
		end
	end

	// Character selection for the current serializer state.
	assign emit = (st_q != ST_IDLE);

	always_comb begin
		char_c = itda_pkg::CHAR_ZERO;
		last_c = 1'b0;
		done   = 1'b0;
		st_n   = st_q;
		pos_n  = pos_q;
		case (st_q)
			ST_SIGN: begin
				char_c = itda_pkg::CHAR_MINUS;
				st_n   = ST_DIGIT;
			end
			ST_DIGIT: begin
				char_c = itda_pkg::CHAR_ZERO + {3'b000, dig_q[pos_q]};
				if (pos_q == '0) begin
					if (nl_q) begin
						st_n = ST_NL;
					end else begin
						last_c = 1'b1;
						done   = 1'b1;
					end
				end else begin
					pos_n = pos_q - IW'(1);
				end
			end
			ST_NL: begin
				char_c = itda_pkg::CHAR_LF;
				last_c = 1'b1;
				done   = 1'b1;
			end
			default: begin
				char_c = itda_pkg::CHAR_ZERO;
			end
		endcase
	end

	// The next request loads in the cycle the current one selects its last character.
	assign ser_ready = (st_q == ST_IDLE) || done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= emit;
			if (ser_ready) begin
				if (vld_s7) begin
					st_q <= neg_s7 ? ST_SIGN : ST_DIGIT;
				end else begin
					st_q <= ST_IDLE;
				end
			end else begin
				st_q <= st_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		char_q <= char_c;
		last_q <= last_c;
		if (ser_ready && vld_s7) begin
			pos_q <= msd_s7;
			nl_q  <= nl_s7;
			for (int d = 0; d < ND; d++) begin
				dig_q[d] <= dig_s7[d];
			end
		end else begin
			pos_q <= pos_n;
		end
	end

	assign strobe    = strobe_q;
	assign character = char_q;
	assign last      = last_q;

	// A sign is always followed by a digit.
	a_sign_then_digit: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_SIGN |=> st_q == ST_DIGIT)
		else $error("sign not followed by a digit");

	// A '-' never ends a conversion.
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && char_q == itda_pkg::CHAR_MINUS |-> !last_q)
		else $error("minus sign marked last");

	// An idle serializer sends nothing in the next cycle.
	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_IDLE |=> !strobe_q)
		else $error("character sent while idle");

	// The digit pointer stays within the digit register.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_DIGIT |-> int'(pos_q) < ND)
		else $error("digit pointer out of range");

	// A full serializer that is not finishing holds the last pipeline stage.
	a_hold_s7: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s7 && !ser_ready |=> vld_s7 && $stable(msd_s7))
		else $error("stalled stage lost its request");

endmodule

// File: sim/int_to_decimal_ascii_tb.sv
// Testbench for the signed integer to decimal ASCII converter: predicted text against the block.
module int_to_decimal_ascii_tb;

	localparam int VALUE_WIDTH  = 32;
	localparam int MAX_DIGITS   = 10;
	localparam int IDLE_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 32;

	// One character of converted text, as the block should emit it.
	typedef struct {
		logic [6:0] character;
		logic       last;
	} text_char_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [31:0] value = '0;
	logic        add_newline = 1'b0;
	logic        strobe;
	logic [6:0]  character;
	logic        last;

	text_char_t expected_text[$];
	int         error_count = 0;
	int         idle_cycles = 0;
	bit         burst_mode = 1'b0;

	int_to_decimal_ascii #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.value      (value),
		.add_newline(add_newline),
		.strobe     (strobe),
		.character  (character),
		.last       (last)
	);

	always #10 clk = ~clk;

	// Prints one mismatch line and counts it.
	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		error_count++;
	endtask

	// Appends the expected text of one request to the store of pending characters.
	function automatic void predict_text(input logic [31:0] v, input logic nl);
		logic [VALUE_WIDTH-1:0] raw;
		logic [VALUE_WIDTH-1:0] mag;
		logic                   neg;
		logic [3:0]             digs[MAX_DIGITS];
		int                     nd;
		text_char_t             c;
		raw = v[VALUE_WIDTH-1:0];
		neg = raw[VALUE_WIDTH-1];
		mag = neg ? -raw : raw;
		nd = 0;
		if (mag == 0) begin
			digs[0] = 4'd0;
			nd = 1;
		end
		while (mag != 0 && nd < MAX_DIGITS) begin
			digs[nd] = 4'(mag % 10);
			mag = mag / 10;
			nd++;
		end
		c.last = 1'b0;
		if (neg) begin
			c.character = itda_pkg::CHAR_MINUS;
			expected_text.push_back(c);
		end
		for (int i = nd - 1; i >= 0; i--) begin
			c.character = itda_pkg::CHAR_ZERO + 7'(digs[i]);
			expected_text.push_back(c);
		end
		if (nl) begin
			c.character = itda_pkg::CHAR_LF;
			expected_text.push_back(c);
		end
		expected_text[expected_text.size() - 1].last = 1'b1;
	endfunction

	// Sends one request after a random gap (none in burst mode) and records its text once it is taken.
	task automatic send_request(input logic [31:0] v, input logic nl);
		int gap;
		gap = burst_mode ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start       <= 1'b1;
		value       <= v;
		add_newline <= nl;
		do @(posedge clk); while (busy);
		predict_text(v, nl);
	endtask

	// Holds the sender off until every pending character has arrived.
	task automatic wait_for_drain();
		start <= 1'b0;
		while (expected_text.size() != 0) @(posedge clk);
	endtask

	// Draws a value with a random sign near a power of ten.
	function automatic logic [31:0] near_power_of_ten();
		logic [31:0] p;
		int          k;
		p = 32'd1;
		k = $urandom_range(0, 9);
		repeat (k) p = p * 10;
		p = p - 32'($urandom_range(0, 1));
		return $urandom_range(0, 1) ? -p : p;
	endfunction

	// Draws a value from a mix of shapes that cover every digit count and sign.
	function automatic logic [31:0] random_value();
		logic [31:0] p;
		logic [31:0] v;
		int          k;
		case ($urandom_range(0, 5))
			0: begin
				v = $urandom;
			end
			1: begin
				v = $urandom_range(0, 20);
				if ($urandom_range(0, 1)) v = -v;
			end
			2: begin
				v = near_power_of_ten();
			end
			3: begin
				case ($urandom_range(0, 3))
					0: v = 32'h8000_0000;
					1: v = 32'h7FFF_FFFF;
					2: v = 32'h0000_0000;
					default: v = 32'hFFFF_FFFF;
				endcase
			end
			4: begin
				p = 32'd1;
				k = $urandom_range(1, 9);
				repeat (k) p = p * 10;
				v = $urandom % p;
				if ($urandom_range(0, 1)) v = -v;
			end
			default: begin
				v = $urandom;
			end
		endcase
		return v;
	endfunction

	// Directed values: zero, the extremes and the edges of the digit counts.
	task automatic test_directed_extremes();
		logic [31:0] vals[12];
		vals = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'd10,
			32'h7FFF_FFFF, 32'h8000_0000, 32'd1000000000, -32'd999999999,
			32'd4294967, -32'd123456789};
		foreach (vals[i]) send_request(vals[i], i[0]);
		send_request(32'd0, 1'b1);
		send_request(32'h8000_0000, 1'b1);
		send_request(32'h7FFF_FFFF, 1'b0);
		send_request(32'hFFFF_FFFF, 1'b1);
		wait_for_drain();
	endtask

	// Random values with random gaps, pausing now and then until the output drains.
	task automatic test_random_values();
		for (int i = 0; i < 110; i++) begin
			send_request(random_value(), 1'($urandom_range(0, 1)));
			if ($urandom_range(0, 39) == 0) wait_for_drain();
		end
		wait_for_drain();
	endtask

	// Back-to-back requests for the first half so the pipeline fills and busy rises, then random gaps.
	task automatic test_back_to_back();
		burst_mode = 1'b1;
		for (int i = 0; i < 40; i++) begin
			if (i == 20) burst_mode = 1'b0;
			send_request(random_value(), 1'($urandom_range(0, 1)));
		end
		burst_mode = 1'b0;
		wait_for_drain();
	endtask

	// Compares each emitted character with the oldest pending one.
	always @(posedge clk) begin
		text_char_t exp_c;
		if (arst_n && strobe) begin
			if (expected_text.size() == 0) begin
				report_mismatch($sformatf("unexpected character %02h last %b", character, last));
			end else begin
				exp_c = expected_text.pop_front();
				if (character !== exp_c.character)
					report_mismatch($sformatf("character %02h, expected %02h",
						character, exp_c.character));
				if (last !== exp_c.last)
					report_mismatch($sformatf("last %b, expected %b", last, exp_c.last));
			end
		end
	end

	// Ends the run when no request is accepted and no character is emitted for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no request or character for %0d cycles", IDLE_LIMIT);
			$display("== FAIL ==");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_extremes();
		test_random_values();
		test_back_to_back();
		start <= 1'b0;
		while (expected_text.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_text.size() != 0)
			report_mismatch($sformatf("%0d characters never arrived", expected_text.size()));
		if (error_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// File: sim.f
src/itda_pkg.sv
src/itda_dabble_stage.sv
src/int_to_decimal_ascii.sv
sim/int_to_decimal_ascii_tb.sv
